[hw/rtl/ptb_pkg.sv]
// ----------------------------------------------------------------------------
// ptb_pkg
// Types and codes shared by the periodic timer bank controller and datapath.
// ----------------------------------------------------------------------------
package ptb_pkg;

  // action codes
  localparam logic [2:0] ACT_TICK         = 3'd0;
  localparam logic [2:0] ACT_SERVICE      = 3'd1;
  localparam logic [2:0] ACT_CREATE       = 3'd2;
  localparam logic [2:0] ACT_SET_INTERVAL = 3'd3;
  localparam logic [2:0] ACT_SET_ENABLE   = 3'd4;
  localparam logic [2:0] ACT_CLEAR_COUNT  = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_FIRE     = 2'd0;
  localparam logic [1:0] KIND_SERVICED = 2'd1;
  localparam logic [1:0] KIND_CREATED  = 2'd2;
  localparam logic [1:0] KIND_FULL     = 2'd3;

  // callback modes
  localparam logic [1:0] MODE_NONE      = 2'd0;
  localparam logic [1:0] MODE_DEFERRED  = 2'd1;
  localparam logic [1:0] MODE_IMMEDIATE = 2'd2;
  localparam logic [1:0] MODE_BOTH      = 2'd3;

  localparam int MAX_RESULTS    = 8;
  localparam int RES_CNT_W      = $clog2(MAX_RESULTS + 1);
  localparam int INTERVAL_WIDTH = 16;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  timer_index;
    logic [15:0] interval_value;
    logic        enable_value;
    logic [1:0]  callback_mode;
  } ptb_in_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [2:0] channel;
    logic       last;
  } ptb_out_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic do_op;
    logic tick_upd;
    logic svc;
    logic flush;
  } ptb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_end;
  } ptb_status_t;

endpackage

[hw/rtl/ptb_ram.sv]
// ----------------------------------------------------------------------------
// ptb_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ptb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/ptb_ctrl.sv]
// ----------------------------------------------------------------------------
// ptb_ctrl
// Sequencer for the timer bank: decodes the item and steps the datapath
// through single updates, tick scans, service scans and the final flush.
// ----------------------------------------------------------------------------
module ptb_ctrl
  import ptb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [2:0]  action,
  input  ptb_status_t status,
  output ptb_cmd_t    cmd,
  output logic        busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_OP,
    S_TICK_RD,
    S_TICK_WR,
    S_SVC,
    S_FLUSH
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            busy <= 1'b1;
            case (action)
              ACT_TICK:    state <= S_TICK_RD;
              ACT_SERVICE: state <= S_SVC;
              ACT_CREATE, ACT_SET_INTERVAL, ACT_SET_ENABLE, ACT_CLEAR_COUNT:
                state <= S_OP;
              default:     state <= S_FLUSH;
            endcase
          end
        end
        S_OP:      state <= S_FLUSH;
        S_TICK_RD: state <= S_TICK_WR;
        S_TICK_WR: begin
          if (status.scan_end) begin
            state <= S_FLUSH;
          end
        end
        S_SVC: begin
          if (status.scan_end) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.capture    = (state == S_IDLE) && start;
    cmd.do_op      = (state == S_OP);
    cmd.tick_upd   = (state == S_TICK_WR);
    cmd.svc        = (state == S_SVC);
    cmd.flush      = (state == S_FLUSH);
  end

endmodule

[hw/rtl/ptb_dp.sv]
// ----------------------------------------------------------------------------
// ptb_dp
// Timer bank datapath: interval, count and mode tables in RAM, enable and
// pending flags, scan index and a one-deep result hold for the last flag.
// ----------------------------------------------------------------------------
module ptb_dp
  import ptb_pkg::*;
#(
  parameter int NUM_TIMERS  = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  ptb_cmd_t    cmd,
  input  ptb_in_t     item,
  output ptb_status_t status,
  output ptb_out_t    result,
  output logic        strobe
);

  localparam int IDXW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int FSW  = $clog2(NUM_TIMERS + 1);
  localparam int CMPW = (COUNT_WIDTH > INTERVAL_WIDTH) ? COUNT_WIDTH : INTERVAL_WIDTH;

  ptb_in_t                 item_q;
  logic [IDXW-1:0]         idx;
  logic [RES_CNT_W-1:0]    n_res;
  logic                    held_valid;
  logic [1:0]              held_kind;
  logic [2:0]              held_chan;
  logic [NUM_TIMERS-1:0]   enable_bits;
  logic [NUM_TIMERS-1:0]   pending_bits;
  logic [NUM_TIMERS-1:0]   iv_valid;
  logic [NUM_TIMERS-1:0]   cnt_valid;
  logic [FSW-1:0]          next_free_slot;

  logic [INTERVAL_WIDTH-1:0] iv_rd, ival_cur;
  logic [COUNT_WIDTH-1:0]    cnt_rd, cnt_cur, cnt_inc;
  logic [1:0]                mode_rd, mode_cur;
  logic [IDXW-1:0]           raddr, ti_addr, slot_addr;
  logic [IDXW+2:0]           idx_ext, ti_ext;
  logic [FSW+2:0]            slot_ext;
  logic [2:0]                idx_chan, slot_chan;
  logic                      ti_ok, full, counting, expire;
  logic                      is_create, is_set_iv, is_set_en, is_clear;

  logic                      iv_we, mode_we, cnt_we;
  logic [IDXW-1:0]           iv_waddr, cnt_waddr;
  logic [COUNT_WIDTH-1:0]    cnt_wdata;

  logic                      cand_valid;
  logic [1:0]                cand_kind;
  logic [2:0]                cand_chan;
  logic                      emit;

  assign status.scan_end = (idx == IDXW'(NUM_TIMERS - 1));

  assign idx_ext   = {3'b000, idx};
  assign idx_chan  = idx_ext[2:0];
  assign ti_ext    = {{IDXW{1'b0}}, item_q.timer_index};
  assign ti_addr   = ti_ext[IDXW-1:0];
  assign ti_ok     = (32'(item_q.timer_index) < NUM_TIMERS);
  assign slot_ext  = {3'b000, next_free_slot};
  assign slot_addr = slot_ext[IDXW-1:0];
  assign slot_chan = slot_ext[2:0];
  assign full      = (32'(next_free_slot) >= NUM_TIMERS);

  assign is_create = (item_q.action == ACT_CREATE);
  assign is_set_iv = (item_q.action == ACT_SET_INTERVAL);
  assign is_set_en = (item_q.action == ACT_SET_ENABLE);
  assign is_clear  = (item_q.action == ACT_CLEAR_COUNT);

  // read ahead of the channel being updated
  assign raddr = (cmd.tick_upd && !status.scan_end) ? idx + IDXW'(1) : idx;

  ptb_ram #(.WIDTH(INTERVAL_WIDTH), .DEPTH(NUM_TIMERS)) u_iv_ram (
    .clk   (clk),
    .we    (iv_we),
    .waddr (iv_waddr),
    .wdata (item_q.interval_value),
    .raddr (raddr),
    .rdata (iv_rd)
  );

  ptb_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_TIMERS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (raddr),
    .rdata (cnt_rd)
  );

  ptb_ram #(.WIDTH(2), .DEPTH(NUM_TIMERS)) u_mode_ram (
    .clk   (clk),
    .we    (mode_we),
    .waddr (slot_addr),
    .wdata (item_q.callback_mode),
    .raddr (raddr),
    .rdata (mode_rd)
  );

  // unwritten entries read as their reset value
  assign ival_cur = iv_valid[idx]  ? iv_rd  : '0;
  assign cnt_cur  = cnt_valid[idx] ? cnt_rd : '0;
  assign mode_cur = (FSW'(idx) < next_free_slot) ? mode_rd : MODE_NONE;

  assign counting = enable_bits[idx] && (ival_cur != '0);
  assign cnt_inc  = cnt_cur + COUNT_WIDTH'(1);
  assign expire   = counting && (CMPW'(cnt_inc) >= CMPW'(ival_cur));

  always_comb begin
    iv_we     = cmd.do_op && ((is_create && !full) || (is_set_iv && ti_ok));
    iv_waddr  = is_create ? slot_addr : ti_addr;
    mode_we   = cmd.do_op && is_create && !full;
    cnt_we    = (cmd.tick_upd && counting) || (cmd.do_op && is_clear && ti_ok);
    cnt_waddr = cmd.tick_upd ? idx : ti_addr;
    cnt_wdata = (cmd.tick_upd && !expire) ? cnt_inc : '0;

    cand_valid = 1'b0;
    cand_kind  = KIND_FIRE;
    cand_chan  = idx_chan;
    if (cmd.tick_upd) begin
      cand_valid = expire && (mode_cur == MODE_IMMEDIATE);
    end else if (cmd.svc) begin
      cand_valid = pending_bits[idx];
      cand_kind  = KIND_SERVICED;
    end else if (cmd.do_op && is_create) begin
      cand_valid = 1'b1;
      cand_kind  = full ? KIND_FULL : KIND_CREATED;
      cand_chan  = full ? 3'd0 : slot_chan;
    end
  end

  assign emit = cand_valid && (32'(n_res) < MAX_RESULTS);

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q <= item;
    end
    if (emit) begin
      held_kind <= cand_kind;
      held_chan <= cand_chan;
      result    <= '{result_kind: held_kind, channel: held_chan, last: 1'b0};
    end else if (cmd.flush) begin
      result    <= '{result_kind: held_kind, channel: held_chan, last: 1'b1};
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idx            <= '0;
      n_res          <= '0;
      held_valid     <= 1'b0;
      strobe         <= 1'b0;
      enable_bits    <= '0;
      pending_bits   <= '0;
      iv_valid       <= '0;
      cnt_valid      <= '0;
      next_free_slot <= '0;
    end else begin
      strobe <= (emit || cmd.flush) && held_valid;

      if (cmd.capture) begin
        idx        <= '0;
        n_res      <= '0;
        held_valid <= 1'b0;
      end

      if ((cmd.tick_upd || cmd.svc) && !status.scan_end) begin
        idx <= idx + IDXW'(1);
      end

      if (emit) begin
        held_valid <= 1'b1;
        n_res      <= n_res + RES_CNT_W'(1);
      end else if (cmd.flush) begin
        held_valid <= 1'b0;
      end

      if (iv_we) begin
        iv_valid[iv_waddr] <= 1'b1;
      end
      if (cnt_we) begin
        cnt_valid[cnt_waddr] <= 1'b1;
      end

      if (cmd.do_op && is_create && !full) begin
        enable_bits[slot_addr] <= item_q.enable_value;
        next_free_slot         <= next_free_slot + FSW'(1);
      end
      if (cmd.do_op && is_set_en && ti_ok) begin
        enable_bits[ti_addr] <= item_q.enable_value;
      end

      if (cmd.tick_upd && expire && (mode_cur == MODE_DEFERRED)) begin
        pending_bits[idx] <= 1'b1;
      end
      if (cmd.svc) begin
        pending_bits[idx] <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/periodic_timer_bank_unit.sv]
// ----------------------------------------------------------------------------
// periodic_timer_bank_unit
// Bank of periodic timer channels with create, tick, service and update items.
//
//   channel   ports                   handshake
//   --------  ----------------------  --------------------------------------
//   item in   start, busy, item       beat taken when start && !busy
//   result    strobe, result          one beat per cycle strobe is high
//
// Tick scans one channel per cycle through the table RAMs after a read
// lead-in state, then flushes. Service scans one pending flag per cycle.
// Create, set and clear items pass through an update state and a flush;
// unused actions go straight to the flush.
// Synchronous reset clears all flags, valid bits and the free-slot pointer.
// Results cannot be stalled; each appears for one cycle with strobe.
// ----------------------------------------------------------------------------
module periodic_timer_bank_unit
  import ptb_pkg::*;
#(
  parameter int NUM_TIMERS  = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  ptb_in_t  item,
  output logic     strobe,
  output ptb_out_t result
);

  ptb_cmd_t    cmd;
  ptb_status_t status;

  ptb_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (item.action),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  ptb_dp #(
    .NUM_TIMERS  (NUM_TIMERS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .status (status),
    .result (result),
    .strobe (strobe)
  );

endmodule
